// ===== rtl/core/rgbct_pkg.sv =====
package rgbct_pkg;

    localparam int FRAC_BITS_DEF = 15;

    localparam logic [1:0] KIND_HSB  = 2'd0;
    localparam logic [1:0] KIND_CTWB = 2'd1;
    localparam logic [1:0] KIND_WB   = 2'd2;

    localparam logic [1:0] REG_COMMAND_PREFIX = 2'd0;
    localparam logic [1:0] REG_RGB_PREFIX     = 2'd1;
    localparam logic [1:0] REG_WHITE_PREFIX   = 2'd2;

    localparam logic [7:0] COMMAND_PREFIX_RST = 8'd120;
    localparam logic [7:0] RGB_PREFIX_RST     = 8'd134;
    localparam logic [7:0] WHITE_PREFIX_RST   = 8'd134;

    // one classified frame handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body2;     // frame-length code byte
        logic [16:0] mx;        // max of rgb
        logic [16:0] diff;      // max - min
        logic [23:0] hue_num;   // |60 * delta| numerator
        logic        hue_neg;
        logic [1:0]  hue_sel;   // 0 red, 1 green, 2 blue max
        logic [7:0]  bright;
        logic [7:0]  wb;
        logic [7:0]  ct;
    } rgbct_job_t;

    function automatic logic [7:0] sat255(input logic [31:0] v);
        return (v > 32'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

// ===== rtl/core/rgbct_front.sv =====
module rgbct_front #(
    parameter int FRAC_BITS = rgbct_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            red,
    input  logic [15:0]            green,
    input  logic [15:0]            blue,
    input  logic [15:0]            colour_temp,
    input  logic [15:0]            white_level,
    input  logic                   link_up,
    output logic                   job_valid,
    input  logic                   job_ready,
    output rgbct_pkg::rgbct_job_t  job
);

    logic [15:0] prev_red_reg, prev_green_reg, prev_blue_reg, prev_ct_reg, prev_wl_reg;
    logic        job_valid_reg;
    rgbct_pkg::rgbct_job_t job_reg, job_next;
    logic        emit, take;
    logic        rgb_moved, ct_changed, white_moved, rgb_zero, none;
    logic [15:0] mx, mn;
    logic [16:0] dlt;
    logic        dneg;
    logic [31:0] bright_w, wb_w, ct_mag;
    logic [31:0] a56, c24;

    assign rgb_moved    = red != prev_red_reg || green != prev_green_reg ||
                          blue != prev_blue_reg;
    assign ct_changed   = colour_temp != prev_ct_reg;
    assign white_moved  = ct_changed || white_level != prev_wl_reg;
    assign rgb_zero     = red == 16'd0 && green == 16'd0 && blue == 16'd0;
    assign none         = !rgb_moved && !white_moved && rgb_zero;

    assign in_ready  = !job_valid_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign emit      = take && link_up && !none;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx) mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        job_next = '0;
        job_next.mx = {1'b0, mx};
        job_next.diff = {1'b0, mx - mn};
        if (mx == red) begin
            job_next.hue_sel = 2'd0;
            dlt = {1'b0, green} - {1'b0, blue};
        end else if (mx == green) begin
            job_next.hue_sel = 2'd1;
            dlt = {1'b0, blue} - {1'b0, red};
        end else begin
            job_next.hue_sel = 2'd2;
            dlt = {1'b0, red} - {1'b0, green};
        end
        dneg = dlt[16];
        job_next.hue_neg = dneg;
        job_next.hue_num = 24'd60 * {7'd0, (dneg ? 17'(-dlt) : dlt)};
        bright_w = (32'(mx) * 32'd100) >> FRAC_BITS;
        wb_w     = (32'(white_level) * 32'd100) >> FRAC_BITS;
        a56      = 32'd56 << FRAC_BITS;
        c24      = 32'd24 * 32'(colour_temp);
        ct_mag   = ((a56 >= c24) ? a56 - c24 : c24 - a56) >> FRAC_BITS;
        job_next.bright = rgbct_pkg::sat255(bright_w);
        job_next.wb     = rgbct_pkg::sat255(wb_w);
        job_next.ct     = rgbct_pkg::sat255(ct_mag);
        if (rgb_moved && white_level == 16'd0) begin
            job_next.kind = rgbct_pkg::KIND_HSB;  job_next.body2 = 8'd4;
        end else if (white_moved && rgb_zero) begin
            if (!ct_changed) begin
                job_next.kind = rgbct_pkg::KIND_WB;  job_next.body2 = 8'd1;
            end else begin
                job_next.kind = rgbct_pkg::KIND_CTWB; job_next.body2 = 8'd2;
            end
        end else begin
            job_next.kind = rgbct_pkg::KIND_HSB;  job_next.body2 = 8'd4;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            prev_red_reg <= '0; prev_green_reg <= '0; prev_blue_reg <= '0;
            prev_ct_reg <= '0;  prev_wl_reg <= '0;
        end else begin
            if (emit) begin
                job_valid_reg <= 1'b1;
                job_reg       <= job_next;
            end else if (job_ready) begin
                job_valid_reg <= 1'b0;
            end
            if (take && !none) begin
                prev_red_reg <= red; prev_green_reg <= green; prev_blue_reg <= blue;
                prev_ct_reg <= colour_temp; prev_wl_reg <= white_level;
            end
        end
    end

endmodule

// ===== rtl/core/rgbct_divider.sv =====
module rgbct_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] num,
    input  logic [16:0] den,
    output logic        busy,
    output logic [23:0] quo,
    output logic [16:0] rem
);
    // restoring divider, one quotient bit per cycle
    logic [4:0]  cnt_reg;
    logic [23:0] q_reg;
    logic [16:0] r_reg;
    logic [17:0] sh;

    assign busy = cnt_reg != 5'd0;
    assign quo  = q_reg;
    assign rem  = r_reg;
    assign sh   = {r_reg, q_reg[23]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= 5'd24;
            q_reg   <= num;
            r_reg   <= '0;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (sh >= {1'b0, den}) begin
                r_reg <= sh[16:0] - den;
                q_reg <= {q_reg[22:0], 1'b1};
            end else begin
                r_reg <= sh[16:0];
                q_reg <= {q_reg[22:0], 1'b0};
            end
        end
    end
endmodule

// ===== rtl/core/rgbct_back.sv =====
module rgbct_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  rgbct_pkg::rgbct_job_t job,
    input  logic [7:0]            command_prefix,
    input  logic [7:0]            rgb_prefix,
    input  logic [7:0]            white_prefix,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            frame_byte,
    output logic [1:0]            frame_kind,
    output logic                  last_byte
);

    typedef enum logic [2:0] {IDLE, DIV_HUE, DIV_SAT, EMIT} state_t;

    state_t                state_reg;
    rgbct_pkg::rgbct_job_t job_reg;
    logic [7:0]  body_reg [7];
    logic [2:0]  len_reg, idx_reg;
    logic [7:0]  sum_reg;
    logic        out_valid_reg, last_reg;
    logic [7:0]  byte_reg;
    logic        started_reg;
    logic        dstart, dbusy;
    logic [23:0] dnum, dquo;
    logic [16:0] dden, drem;
    logic [8:0]  hue;
    logic [9:0]  h_tmp;

    rgbct_divider u_div (
        .aclk, .aresetn, .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quo(dquo), .rem(drem)
    );

    assign job_ready  = state_reg == IDLE;
    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_kind = job_reg.kind;
    assign last_byte  = last_reg;

    assign dstart = (state_reg == DIV_HUE || state_reg == DIV_SAT) && !started_reg;
    assign dnum   = (state_reg == DIV_HUE) ? job_reg.hue_num
                  : 24'(32'(job_reg.diff) * 32'd100);
    assign dden   = (state_reg == DIV_HUE) ? job_reg.diff : job_reg.mx;

    // hue from truncated quotient; floor for negative non-red cases
    always_comb begin
        h_tmp = 10'd0;
        unique case (job_reg.hue_sel)
            2'd0: h_tmp = job_reg.hue_neg ? 10'd360 - 10'(dquo) : 10'(dquo);
            2'd1: h_tmp = job_reg.hue_neg
                          ? 10'd120 - 10'(dquo) - 10'(drem != 17'd0)
                          : 10'd120 + 10'(dquo);
            default: h_tmp = job_reg.hue_neg
                          ? 10'd240 - 10'(dquo) - 10'(drem != 17'd0)
                          : 10'd240 + 10'(dquo);
        endcase
        if (job_reg.diff == 17'd0) h_tmp = 10'd0;
        if (h_tmp >= 10'd360) h_tmp = h_tmp - 10'd360;
        hue = h_tmp[8:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (job_valid) begin
                        job_reg     <= job;
                        body_reg[0] <= command_prefix;
                        body_reg[2] <= job.body2;
                        idx_reg     <= '0;
                        sum_reg     <= '0;
                        started_reg <= 1'b0;
                        if (job.kind == rgbct_pkg::KIND_HSB) begin
                            body_reg[1] <= rgb_prefix;
                            body_reg[6] <= job.bright;
                            len_reg     <= 3'd7;
                            state_reg   <= DIV_HUE;
                        end else begin
                            body_reg[1] <= white_prefix;
                            body_reg[3] <= job.wb;
                            body_reg[4] <= job.ct;
                            len_reg     <= (job.kind == rgbct_pkg::KIND_WB) ? 3'd4 : 3'd5;
                            state_reg   <= EMIT;
                        end
                    end
                end
                DIV_HUE: begin
                    if (started_reg && !dbusy) begin
                        body_reg[3] <= hue[7:0];
                        body_reg[4] <= {7'd0, hue[8]};
                        started_reg <= 1'b0;
                        state_reg   <= DIV_SAT;
                    end else begin
                        started_reg <= 1'b1;
                    end
                end
                DIV_SAT: begin
                    started_reg <= 1'b1;
                    if (started_reg && !dbusy) begin
                        body_reg[5] <= (job_reg.mx == 17'd0) ? 8'd0 : dquo[7:0];
                        state_reg   <= EMIT;
                    end
                end
                EMIT: begin
                    if (!out_valid_reg || out_ready) begin
                        if (last_reg && out_valid_reg) begin
                            out_valid_reg <= 1'b0;
                            last_reg      <= 1'b0;
                            state_reg     <= IDLE;
                        end else if (idx_reg == len_reg) begin
                            out_valid_reg <= 1'b1;
                            byte_reg      <= sum_reg;
                            last_reg      <= 1'b1;
                        end else begin
                            out_valid_reg <= 1'b1;
                            byte_reg      <= body_reg[idx_reg];
                            sum_reg       <= sum_reg + body_reg[idx_reg];
                            last_reg      <= 1'b0;
                            idx_reg       <= idx_reg + 3'd1;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/rgbct_light_command_encoder.sv =====
// Path: input transfer to first m_tvalid goes through load, the hue and saturation serial
//   divisions (HSB only) and byte register, then one byte per cycle while m_tready is high.
// Flow: the back end takes a new frame only when idle; one queued frame in the front
//   lets the next item in meanwhile; no-frame items one per cycle unless a frame waits.
// Reset: synchronous active-low aresetn clears stored setting, prefixes to
//   120/134/134, and drops any frame in flight.
module rgbct_light_command_encoder #(
    parameter int FRAC_BITS = rgbct_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // red, green, blue, colour_temp, white_level, link_up, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte
    output logic [1:0]  m_tuser,   // frame_kind
    output logic        m_tlast,   // last_byte
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] cmd_prefix_reg, rgb_prefix_reg, white_prefix_reg;
    logic                  job_valid, job_ready;
    rgbct_pkg::rgbct_job_t job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_prefix_reg   <= rgbct_pkg::COMMAND_PREFIX_RST;
            rgb_prefix_reg   <= rgbct_pkg::RGB_PREFIX_RST;
            white_prefix_reg <= rgbct_pkg::WHITE_PREFIX_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rgbct_pkg::REG_COMMAND_PREFIX: cmd_prefix_reg   <= cfg_data;
                rgbct_pkg::REG_RGB_PREFIX:     rgb_prefix_reg   <= cfg_data;
                rgbct_pkg::REG_WHITE_PREFIX:   white_prefix_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: compare against stored setting, classify, precompute
    rgbct_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .red(s_tdata[15:0]), .green(s_tdata[31:16]), .blue(s_tdata[47:32]),
        .colour_temp(s_tdata[63:48]), .white_level(s_tdata[79:64]),
        .link_up(s_tdata[80]),
        .job_valid, .job_ready, .job
    );

    // back: divisions, byte serialization, checksum
    rgbct_back u_back (
        .aclk, .aresetn, .job_valid, .job_ready, .job,
        .command_prefix(cmd_prefix_reg), .rgb_prefix(rgb_prefix_reg),
        .white_prefix(white_prefix_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .frame_byte(m_tdata), .frame_kind(m_tuser), .last_byte(m_tlast)
    );

endmodule

// ===== rtl/core/rgbct_checker.sv =====
module rgbct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3) else $error("bad frame kind");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("stall lost");
    a_kind_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> $stable(m_tuser))
        else $error("kind changed mid frame");
endmodule

bind rgbct_light_command_encoder rgbct_checker u_chk (.*);
